// File: hdl/lsfo_pkg.sv
// Shared constants, types and codes for the tank level observer controller.
package lsfo_pkg;

    // Stream payload layout
    localparam int ECHO_FIELDS    = 5;
    localparam int ECHO_W         = 15;
    localparam int IN_DATA_W      = 80;
    localparam int OUT_DATA_W     = 96;
    localparam int ACTION_W       = 2;

    // Configuration port
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 32;

    // Fixed point formats
    localparam int FIX_W          = 32;
    localparam int TANK_W         = 31;
    localparam int DRIVE_W        = 23;
    localparam int DUTY_W         = 8;
    localparam int DRIVE_MAX      = 6553600;

    // Arithmetic units
    localparam int ECHO_COUNT_DEF = 5;
    localparam int MUL_W          = 32;
    localparam int MUL_DIGIT_DEF  = 4;
    localparam int DIV_NW         = 48;
    localparam int STEP_DIV       = 100;
    localparam int STEP_BIAS      = 3276800;

    // Plant coefficients scaled by 2^32
    localparam logic signed [MUL_W-1:0] COEF_A = -32'sd22333830;
    localparam logic signed [MUL_W-1:0] COEF_B = 32'sd84610855;

    // Register reset values
    localparam logic signed [FIX_W-1:0] RST_GAIN_REGULATOR = 32'sd3309404;
    localparam logic signed [FIX_W-1:0] RST_GAIN_OBSERVER  = 32'sd655019;
    localparam logic signed [FIX_W-1:0] RST_STATE_SCALE    = 32'sd65536;
    localparam logic signed [FIX_W-1:0] RST_DRIVE_SCALE    = 32'sd17302;
    localparam logic signed [FIX_W-1:0] RST_REFERENCE      = 32'sd655360;
    localparam logic [TANK_W-1:0]       RST_TANK_HEIGHT    = 31'd1310720;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_REGULATOR = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_OBSERVER  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_STATE_SCALE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DRIVE_SCALE    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_REFERENCE      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_TANK_HEIGHT    = 3'd5;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_START = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_STOP  = 2'd2;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_XSS,
        ST_USS,
        ST_FB,
        ST_AX,
        ST_BU,
        ST_DIST,
        ST_OBS,
        ST_STEP,
        ST_DONE
    } lsfo_state_t;

    // Status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } lsfo_unit_stat_t;

endpackage

// File: hdl/level_state_feedback_observer_core.sv
// Top level: tank level state feedback controller with a serial observer datapath.
//
// Channel  Direction  Handshake          Payload
// s_*      in         s_tvalid/s_tready  tuser: action; tdata: echo_a..echo_e
// m_*      out        m_tvalid/m_tready  tdata: running, levels, drive, duty
// cfg_*    in         cfg_wr_en          cfg_index selects register, cfg_wdata
//
// A control tick while running computes six products on the shared digit-serial
// multiplier and two 48-bit quotients on the one-bit-per-cycle divider. Start,
// stop and ignored items skip the arithmetic. Items are taken one at a time.
// Reset restores the register defaults, stops the loop and zeroes estimate
// and drive. A stalled result waits in the output register; the next item
// is already accepted and held at its end until the result is taken.
module level_state_feedback_observer_core #(
    parameter int ECHO_COUNT = lsfo_pkg::ECHO_COUNT_DEF,
    parameter int MUL_DIGIT  = lsfo_pkg::MUL_DIGIT_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // echo_a [14:0], echo_b [29:15], echo_c [44:30], echo_d [59:45], echo_e [74:60]
    input  logic [lsfo_pkg::IN_DATA_W-1:0]     s_tdata,
    // action [1:0]
    input  logic [lsfo_pkg::ACTION_W-1:0]      s_tuser,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // running [0], measured_level [32:1], estimated_level [64:33],
    // drive_percent [87:65], pwm_duty [95:88]
    output logic [lsfo_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_wr_en,
    input  logic [lsfo_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lsfo_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int SUMMED    = (ECHO_COUNT < lsfo_pkg::ECHO_FIELDS) ?
                               ECHO_COUNT : lsfo_pkg::ECHO_FIELDS;
    localparam int SUM_W     = lsfo_pkg::ECHO_W + $clog2(SUMMED + 1);
    localparam int DIST_DIV  = 58 * ECHO_COUNT;
    localparam int DIST_BIAS = 29 * ECHO_COUNT;
    localparam int DVW_DIST  = $clog2(DIST_DIV + 1);
    localparam int DVW_STEP  = $clog2(lsfo_pkg::STEP_DIV + 1);
    localparam int DIV_VW    = (DVW_DIST > DVW_STEP) ? DVW_DIST : DVW_STEP;
    localparam int NW        = lsfo_pkg::DIV_NW;
    localparam int FW        = lsfo_pkg::FIX_W;
    localparam int PW        = 2 * lsfo_pkg::MUL_W;
    localparam int RND_W     = PW - 15;
    localparam int SAT_W     = RND_W + 1;
    localparam int ACC_W     = PW + 1;
    localparam int DW        = lsfo_pkg::DRIVE_W;
    localparam int DUTY_RECIP = 41944;
    localparam int DUTY_SHIFT = 22;

    // Round a product by 16 fraction bits, half up
    function automatic logic signed [RND_W-1:0] rnd16(input logic signed [PW-1:0] p);
        logic signed [PW:0] v;
        v = (PW+1)'(p) + (PW+1)'(32768);
        return v[PW:16];
    endfunction

    // Saturate to a 32-bit signed value
    function automatic logic signed [FW-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = SAT_W'(32'sh7FFFFFFF);
        lo = SAT_W'(32'sh80000000);
        if (v > hi)
        begin
            return 32'sh7FFFFFFF;
        end
        else if (v < lo)
        begin
            return 32'sh80000000;
        end
        return v[FW-1:0];
    endfunction

    // Configuration registers
    logic signed [FW-1:0]              k_reg;
    logic signed [FW-1:0]              ke_reg;
    logic signed [FW-1:0]              nx_reg;
    logic signed [FW-1:0]              nu_reg;
    logic signed [FW-1:0]              ref_reg;
    logic [lsfo_pkg::TANK_W-1:0]       tank_reg;

    // Sequencer and loop state
    lsfo_pkg::lsfo_state_t             state_reg, state_next;
    logic                              launched_reg, launched_next;
    logic                              run_reg, run_next;
    logic signed [FW-1:0]              x_reg, x_next;
    logic [DW-1:0]                     drive_reg, drive_next;
    logic signed [FW-1:0]              meas_reg, meas_next;
    logic [SUM_W-1:0]                  sum_reg, sum_next;
    logic signed [FW-1:0]              xss_reg, xss_next;
    logic signed [FW-1:0]              uss_reg, uss_next;
    logic signed [ACC_W-1:0]           acc_reg, acc_next;
    logic                              out_valid_reg, out_valid_next;
    logic [lsfo_pkg::OUT_DATA_W-1:0]   out_data_reg, out_data_next;

    // Arithmetic unit connections
    logic                              mul_start;
    logic signed [lsfo_pkg::MUL_W-1:0] mul_a;
    logic signed [lsfo_pkg::MUL_W-1:0] mul_b;
    lsfo_pkg::lsfo_unit_stat_t         mul_stat;
    logic signed [PW-1:0]              mul_prod;
    logic                              div_start;
    logic [NW-1:0]                     div_dividend;
    logic [DIV_VW-1:0]                 div_divisor;
    lsfo_pkg::lsfo_unit_stat_t         div_stat;
    logic [NW-1:0]                     div_quot;

    // Datapath intermediates
    logic [SUM_W-1:0]                  sum_in;
    logic signed [FW-1:0]              err;
    logic signed [FW-1:0]              innov;
    logic signed [RND_W-1:0]           prod_rnd;
    logic signed [SAT_W-1:0]           u_full;
    logic signed [ACC_W-1:0]           xa;
    logic signed [RND_W-1:0]           w;
    logic                              w_neg;
    logic [NW-1:0]                     w_mag;
    logic signed [RND_W-1:0]           q_step;
    logic [DIST_DIV > 0 ? NW-1 : 0:0]  dist_dividend;
    logic [6:0]                        duty_int;
    logic [14:0]                       duty_scaled;
    logic [30:0]                       duty_prod;
    logic [lsfo_pkg::DUTY_W-1:0]       duty;

    lsfo_serial_mul #(
        .W (lsfo_pkg::MUL_W),
        .D (MUL_DIGIT)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .stat    (mul_stat),
        .product (mul_prod)
    );

    lsfo_serial_div #(
        .NW (NW),
        .VW (DIV_VW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    // Sum the echo widths of the incoming item
    always_comb
    begin
        sum_in = '0;
        for (int i = 0; i < SUMMED; i++)
        begin
            sum_in = sum_in + SUM_W'(s_tdata[i*lsfo_pkg::ECHO_W +: lsfo_pkg::ECHO_W]);
        end
    end

    // Shared datapath terms
    always_comb
    begin
        err           = sat32(SAT_W'(x_reg) - SAT_W'(xss_reg));
        innov         = sat32(SAT_W'(meas_reg) - SAT_W'(x_reg));
        prod_rnd      = rnd16(mul_prod);
        u_full        = SAT_W'(uss_reg) - SAT_W'(prod_rnd);
        xa            = acc_reg + ACC_W'(lsfo_pkg::STEP_BIAS);
        w             = xa[ACC_W-1:16];
        w_neg         = w[RND_W-1];
        w_mag         = w_neg ? ~w[NW-1:0] : w[NW-1:0];
        q_step        = w_neg ? ~signed'({1'b0, div_quot}) : signed'({1'b0, div_quot});
        dist_dividend = NW'({sum_reg, 16'b0}) + NW'(DIST_BIAS);
    end

    // Duty from the integer percent, via a reciprocal of 100
    always_comb
    begin
        duty_int    = drive_reg[DW-1:16];
        duty_scaled = {duty_int, 8'b0} - 15'(duty_int);
        duty_prod   = 31'(duty_scaled) * 31'(DUTY_RECIP);
        duty        = duty_prod[DUTY_SHIFT +: lsfo_pkg::DUTY_W];
    end

    // Select multiplier and divider operands by step
    always_comb
    begin
        mul_a        = nx_reg;
        mul_b        = ref_reg;
        div_dividend = dist_dividend;
        div_divisor  = DIV_VW'(DIST_DIV);
        case (state_reg)
            lsfo_pkg::ST_USS:
            begin
                mul_a = nu_reg;
                mul_b = ref_reg;
            end
            lsfo_pkg::ST_FB:
            begin
                mul_a = k_reg;
                mul_b = err;
            end
            lsfo_pkg::ST_AX:
            begin
                mul_a = lsfo_pkg::COEF_A;
                mul_b = x_reg;
            end
            lsfo_pkg::ST_BU:
            begin
                mul_a = lsfo_pkg::COEF_B;
                mul_b = signed'(FW'(drive_reg));
            end
            lsfo_pkg::ST_OBS:
            begin
                mul_a = ke_reg;
                mul_b = innov;
            end
            lsfo_pkg::ST_STEP:
            begin
                div_dividend = w_mag;
                div_divisor  = DIV_VW'(lsfo_pkg::STEP_DIV);
            end
            default:
            begin
            end
        endcase
    end

    // Sequence one item through the serial units
    always_comb
    begin
        state_next     = state_reg;
        launched_next  = launched_reg;
        run_next       = run_reg;
        x_next         = x_reg;
        drive_next     = drive_reg;
        meas_next      = meas_reg;
        sum_next       = sum_reg;
        xss_next       = xss_reg;
        uss_next       = uss_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        mul_start      = 1'b0;
        div_start      = 1'b0;
        s_tready       = (state_reg == lsfo_pkg::ST_IDLE);

        case (state_reg)
            lsfo_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    meas_next  = '0;
                    state_next = lsfo_pkg::ST_DONE;
                    case (s_tuser)
                        lsfo_pkg::ACT_START:
                        begin
                            run_next = 1'b1;
                        end
                        lsfo_pkg::ACT_STOP:
                        begin
                            run_next   = 1'b0;
                            drive_next = '0;
                        end
                        lsfo_pkg::ACT_TICK:
                        begin
                            if (run_reg)
                            begin
                                sum_next   = sum_in;
                                state_next = lsfo_pkg::ST_XSS;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            lsfo_pkg::ST_XSS, lsfo_pkg::ST_USS, lsfo_pkg::ST_FB,
            lsfo_pkg::ST_AX, lsfo_pkg::ST_BU, lsfo_pkg::ST_OBS:
            begin
                if (!launched_reg)
                begin
                    mul_start     = 1'b1;
                    launched_next = 1'b1;
                end
                else if (mul_stat.done)
                begin
                    launched_next = 1'b0;
                    case (state_reg)
                        lsfo_pkg::ST_XSS:
                        begin
                            xss_next   = sat32(SAT_W'(prod_rnd));
                            state_next = lsfo_pkg::ST_USS;
                        end
                        lsfo_pkg::ST_USS:
                        begin
                            uss_next   = sat32(SAT_W'(prod_rnd));
                            state_next = lsfo_pkg::ST_FB;
                        end
                        lsfo_pkg::ST_FB:
                        begin
                            // Clamp the drive to 0..100 percent
                            if (u_full < 0)
                            begin
                                drive_next = '0;
                            end
                            else if (u_full > SAT_W'(lsfo_pkg::DRIVE_MAX))
                            begin
                                drive_next = DW'(lsfo_pkg::DRIVE_MAX);
                            end
                            else
                            begin
                                drive_next = u_full[DW-1:0];
                            end
                            state_next = lsfo_pkg::ST_AX;
                        end
                        lsfo_pkg::ST_AX:
                        begin
                            acc_next   = ACC_W'(prod_rnd);
                            state_next = lsfo_pkg::ST_BU;
                        end
                        lsfo_pkg::ST_BU:
                        begin
                            acc_next   = acc_reg + ACC_W'(prod_rnd);
                            state_next = lsfo_pkg::ST_DIST;
                        end
                        default:
                        begin
                            acc_next   = acc_reg + ACC_W'(mul_prod);
                            state_next = lsfo_pkg::ST_STEP;
                        end
                    endcase
                end
            end

            lsfo_pkg::ST_DIST, lsfo_pkg::ST_STEP:
            begin
                if (!launched_reg)
                begin
                    div_start     = 1'b1;
                    launched_next = 1'b1;
                end
                else if (div_stat.done)
                begin
                    launched_next = 1'b0;
                    if (state_reg == lsfo_pkg::ST_DIST)
                    begin
                        // Level is tank height minus the averaged distance
                        meas_next  = signed'({1'b0, tank_reg} - div_quot[FW-1:0]);
                        state_next = lsfo_pkg::ST_OBS;
                    end
                    else
                    begin
                        x_next     = sat32(SAT_W'(x_reg) + SAT_W'(q_step));
                        state_next = lsfo_pkg::ST_DONE;
                    end
                end
            end

            lsfo_pkg::ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {duty, drive_reg, x_reg, meas_reg, run_reg};
                    state_next     = lsfo_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = lsfo_pkg::ST_IDLE;
            end
        endcase
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg    <= lsfo_pkg::RST_GAIN_REGULATOR;
            ke_reg   <= lsfo_pkg::RST_GAIN_OBSERVER;
            nx_reg   <= lsfo_pkg::RST_STATE_SCALE;
            nu_reg   <= lsfo_pkg::RST_DRIVE_SCALE;
            ref_reg  <= lsfo_pkg::RST_REFERENCE;
            tank_reg <= lsfo_pkg::RST_TANK_HEIGHT;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                lsfo_pkg::REG_GAIN_REGULATOR: k_reg    <= signed'(cfg_wdata);
                lsfo_pkg::REG_GAIN_OBSERVER:  ke_reg   <= signed'(cfg_wdata);
                lsfo_pkg::REG_STATE_SCALE:    nx_reg   <= signed'(cfg_wdata);
                lsfo_pkg::REG_DRIVE_SCALE:    nu_reg   <= signed'(cfg_wdata);
                lsfo_pkg::REG_REFERENCE:      ref_reg  <= signed'(cfg_wdata);
                lsfo_pkg::REG_TANK_HEIGHT:    tank_reg <= cfg_wdata[lsfo_pkg::TANK_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Hold control and loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lsfo_pkg::ST_IDLE;
            launched_reg  <= 1'b0;
            run_reg       <= 1'b0;
            x_reg         <= '0;
            drive_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            launched_reg  <= launched_next;
            run_reg       <= run_next;
            x_reg         <= x_next;
            drive_reg     <= drive_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold datapath payload
    always_ff @(posedge clk)
    begin
        meas_reg     <= meas_next;
        sum_reg      <= sum_next;
        xss_reg      <= xss_next;
        uss_reg      <= uss_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // Drive never leaves the clamp range
    assert property (@(posedge clk) disable iff (!rst_n)
        drive_reg <= DW'(lsfo_pkg::DRIVE_MAX))
    else $error("drive above full scale");

    // A stop transfer clears the run flag and the drive
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == lsfo_pkg::ACT_STOP) |=>
        (!run_reg && drive_reg == '0))
    else $error("stop did not clear run flag and drive");

    // Estimate holds while stopped
    assert property (@(posedge clk) disable iff (!rst_n)
        !run_reg |=> $stable(x_reg))
    else $error("estimate moved while stopped");

    // Multiplier is launched only when both units are free
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_start |-> (!mul_stat.busy && !div_stat.busy))
    else $error("multiplier launched while a unit is busy");
`endif

endmodule

// File: hdl/lsfo_serial_mul.sv
// Digit-serial signed multiplier: one multiplier digit per cycle.
module lsfo_serial_mul #(
    parameter int W = lsfo_pkg::MUL_W,
    parameter int D = lsfo_pkg::MUL_DIGIT_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [W-1:0]       op_a,
    input  logic signed [W-1:0]       op_b,
    output lsfo_pkg::lsfo_unit_stat_t stat,
    output logic signed [2*W-1:0]     product
);

    localparam int STEPS = (W + D - 1) / D;
    localparam int BW    = STEPS * D;
    localparam int PW    = 2 * W;
    localparam int CW    = $clog2(STEPS + 1);

    logic signed [PW-1:0] a_sh_reg, a_sh_next;
    logic [BW-1:0]        b_reg, b_next;
    logic signed [PW-1:0] acc_reg, acc_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic                 last_step;
    logic signed [D:0]    dig;
    logic signed [PW-1:0] pp;

    // Partial product of the shifted multiplicand and the current digit;
    // the top digit carries the sign of the multiplier
    always_comb
    begin
        last_step = (cnt_reg == CW'(1));
        if (last_step)
        begin
            dig = signed'({b_reg[D-1], b_reg[D-1:0]});
        end
        else
        begin
            dig = signed'({1'b0, b_reg[D-1:0]});
        end
        pp = a_sh_reg * PW'(dig);
    end

    // Load operands, then advance one digit per cycle
    always_comb
    begin
        a_sh_next = a_sh_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_sh_next = PW'(op_a);
            b_next    = BW'(op_b);
            acc_next  = '0;
            cnt_next  = CW'(STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next  = acc_reg + pp;
            a_sh_next = a_sh_reg <<< D;
            b_next    = b_reg >> D;
            cnt_next  = cnt_reg - CW'(1);
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold operands and partial sum
    always_ff @(posedge clk)
    begin
        a_sh_reg <= a_sh_next;
        b_reg    <= b_next;
        acc_reg  <= acc_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = acc_reg;

endmodule

// File: hdl/lsfo_serial_div.sv
// Bit-serial restoring divider for unsigned operands: one quotient bit per cycle.
module lsfo_serial_div #(
    parameter int NW = lsfo_pkg::DIV_NW,
    parameter int VW = 9
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [NW-1:0]             dividend,
    input  logic [VW-1:0]             divisor,
    output lsfo_pkg::lsfo_unit_stat_t stat,
    output logic [NW-1:0]             quotient
);

    localparam int CW = $clog2(NW + 1);

    logic [VW-1:0] rem_reg, rem_next;
    logic [NW-1:0] q_reg, q_next;
    logic [VW-1:0] dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          ge;

    // Trial subtract of the divisor from the partial remainder
    always_comb
    begin
        trial = {rem_reg, q_reg[NW-1]};
        diff  = trial - {1'b0, dvs_reg};
        ge    = (trial >= {1'b0, dvs_reg});
    end

    // Load the dividend, then shift in one quotient bit per cycle
    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            q_next    = dividend;
            dvs_next  = divisor;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[VW-1:0] : trial[VW-1:0];
            q_next   = {q_reg[NW-2:0], ge};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold remainder, quotient and divisor
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = q_reg;

endmodule

// File: dv/level_state_feedback_observer_core_tb.sv
// Self-checking stream testbench for the tank level observer controller core.
`timescale 1ns / 1ps

module level_state_feedback_observer_core_tb;

    localparam int     ECHO_N      = 5;
    localparam int     CYCLE_LIMIT = 1000000;
    localparam int     TAIL_CYCLES = 400;
    localparam longint PLANT_A     = -64'sd22333830;
    localparam longint PLANT_B     = 64'sd84610855;
    localparam longint DRIVE_TOP   = 64'sd6553600;
    localparam longint STEP_DEN    = 64'sd6553600;
    localparam longint STEP_HALF   = 64'sd3276800;
    localparam logic [lsfo_pkg::ACTION_W-1:0] ACT_IGNORED = 2'd3;
    localparam logic [lsfo_pkg::ECHO_W-1:0]   ECHO_TOP    = 15'd25000;
    localparam logic [lsfo_pkg::ECHO_W-1:0]   ECHO_ALL1   = 15'h7FFF;

    // One input transfer: action in tuser, echo_a at the lowest bits of tdata
    typedef struct packed {
        logic [lsfo_pkg::ACTION_W-1:0]           action;
        logic [ECHO_N-1:0][lsfo_pkg::ECHO_W-1:0] echoes;
    } level_cmd_t;

    // One output transfer, packed to match m_tdata
    typedef struct packed {
        logic [lsfo_pkg::DUTY_W-1:0]  duty;
        logic [lsfo_pkg::DRIVE_W-1:0] drive;
        logic [lsfo_pkg::FIX_W-1:0]   estimate;
        logic [lsfo_pkg::FIX_W-1:0]   measured;
        logic                         running;
    } level_report_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic [lsfo_pkg::IN_DATA_W-1:0]   s_tdata = '0;
    logic [lsfo_pkg::ACTION_W-1:0]    s_tuser = '0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [lsfo_pkg::OUT_DATA_W-1:0]  m_tdata;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic                             cfg_wr_en = 1'b0;
    logic [lsfo_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [lsfo_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

    // Mirror of the controller registers and loop state
    logic signed [lsfo_pkg::FIX_W-1:0] k_gain    = 32'sd3309404;
    logic signed [lsfo_pkg::FIX_W-1:0] ke_gain   = 32'sd655019;
    logic signed [lsfo_pkg::FIX_W-1:0] nx_scale  = 32'sd65536;
    logic signed [lsfo_pkg::FIX_W-1:0] nu_scale  = 32'sd17302;
    logic signed [lsfo_pkg::FIX_W-1:0] ref_level = 32'sd655360;
    logic [lsfo_pkg::TANK_W-1:0]       tank_h    = 31'd1310720;
    logic                              run_on    = 1'b0;
    logic signed [lsfo_pkg::FIX_W-1:0] est_q     = '0;
    logic [lsfo_pkg::DRIVE_W-1:0]      drive_q   = '0;

    level_cmd_t    cmd_queue[$];
    level_report_t loop_expect[$];
    level_report_t seen_rpt;
    level_report_t want_rpt;

    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    int err_count     = 0;
    int result_count  = 0;
    int cycle_count   = 0;

    level_state_feedback_observer_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Saturate to the signed 32-bit range
    function automatic logic signed [lsfo_pkg::FIX_W-1:0] clip32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[lsfo_pkg::FIX_W-1:0];
    endfunction

    // Round to nearest, dropping 16 fraction bits (ties toward +inf)
    function automatic longint round_q16(input longint v);
        return (v + 64'sd32768) >>> 16;
    endfunction

    function automatic longint floor_div(input longint n, input longint d);
        longint q;
        q = n / d;
        if (n < 0 && q * d != n)
            q = q - 1;
        return q;
    endfunction

    // Advance the controller mirror by one accepted item and return its report
    function automatic level_report_t step_level_loop(input level_cmd_t c);
        level_report_t r;
        logic signed [lsfo_pkg::FIX_W-1:0] meas;
        longint sum;
        longint dist_q16;
        longint x;
        longint xss;
        longint uss;
        longint err;
        longint u;
        longint innov;
        longint xdot;
        meas = '0;
        case (c.action)
            lsfo_pkg::ACT_START: run_on = 1'b1;
            lsfo_pkg::ACT_STOP:
            begin
                run_on  = 1'b0;
                drive_q = '0;
            end
            lsfo_pkg::ACT_TICK:
            begin
                if (run_on)
                begin
                    // echo widths to distance, then level below the sensor
                    sum = 0;
                    for (int i = 0; i < ECHO_N; i++)
                        sum = sum + longint'(c.echoes[i]);
                    dist_q16 = (sum * 65536 + 29 * ECHO_N) / (58 * ECHO_N);
                    meas = clip32(longint'(tank_h) - dist_q16);

                    // state feedback with reference feed-forward
                    x   = longint'(est_q);
                    xss = longint'(clip32(round_q16(longint'(nx_scale) *
                                                    longint'(ref_level))));
                    uss = longint'(clip32(round_q16(longint'(nu_scale) *
                                                    longint'(ref_level))));
                    err = longint'(clip32(x - xss));
                    u   = uss - round_q16(longint'(k_gain) * err);
                    if (u < 0)
                        u = 0;
                    if (u > DRIVE_TOP)
                        u = DRIVE_TOP;
                    drive_q = u[lsfo_pkg::DRIVE_W-1:0];

                    // observer update over one 10 ms step
                    innov = longint'(clip32(longint'(meas) - x));
                    xdot  = round_q16(PLANT_A * x) + round_q16(PLANT_B * u)
                          + longint'(ke_gain) * innov;
                    est_q = clip32(x + floor_div(xdot + STEP_HALF, STEP_DEN));
                end
            end
            default: ;
        endcase
        r.running  = run_on;
        r.measured = meas;
        r.estimate = est_q;
        r.drive    = drive_q;
        r.duty     = lsfo_pkg::DUTY_W'((int'(drive_q >> 16) * 255) / 100);
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch at result %0d: %s got %h want %h",
                 result_count, what, got, want);
        err_count++;
    endtask

    task automatic push_cmd(input logic [lsfo_pkg::ACTION_W-1:0] act,
                            input logic [lsfo_pkg::ECHO_W-1:0] ea,
                            input logic [lsfo_pkg::ECHO_W-1:0] eb,
                            input logic [lsfo_pkg::ECHO_W-1:0] ec,
                            input logic [lsfo_pkg::ECHO_W-1:0] ed,
                            input logic [lsfo_pkg::ECHO_W-1:0] ee);
        level_cmd_t c;
        c.action = act;
        c.echoes = {ee, ed, ec, eb, ea};
        cmd_queue.push_back(c);
    endtask

    // Random item: mostly ticks with echoes clustered around one distance
    function automatic level_cmd_t make_cmd();
        level_cmd_t c;
        int pick;
        int base;
        int jit;
        pick = $urandom_range(99);
        if (pick < 84)
            c.action = lsfo_pkg::ACT_TICK;
        else if (pick < 90)
            c.action = lsfo_pkg::ACT_START;
        else if (pick < 96)
            c.action = lsfo_pkg::ACT_STOP;
        else
            c.action = ACT_IGNORED;
        base = $urandom_range(ECHO_TOP);
        for (int i = 0; i < ECHO_N; i++)
        begin
            pick = $urandom_range(19);
            if (pick == 0)
                c.echoes[i] = '0;
            else if (pick == 1)
                c.echoes[i] = lsfo_pkg::ECHO_W'($urandom_range(ECHO_ALL1));
            else
            begin
                jit = base + int'($urandom_range(200)) - 100;
                if (jit < 0)
                    jit = 0;
                if (jit > ECHO_TOP)
                    jit = ECHO_TOP;
                c.echoes[i] = lsfo_pkg::ECHO_W'(jit);
            end
        end
        return c;
    endfunction

    task automatic write_reg(input logic [lsfo_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [31:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            lsfo_pkg::REG_GAIN_REGULATOR: k_gain    = val;
            lsfo_pkg::REG_GAIN_OBSERVER:  ke_gain   = val;
            lsfo_pkg::REG_STATE_SCALE:    nx_scale  = val;
            lsfo_pkg::REG_DRIVE_SCALE:    nu_scale  = val;
            lsfo_pkg::REG_REFERENCE:      ref_level = val;
            lsfo_pkg::REG_TANK_HEIGHT:    tank_h    = val[lsfo_pkg::TANK_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [31:0] k, input logic [31:0] ke,
                             input logic [31:0] nx, input logic [31:0] nu,
                             input logic [31:0] rl, input logic [31:0] th);
        write_reg(lsfo_pkg::REG_GAIN_REGULATOR, k);
        write_reg(lsfo_pkg::REG_GAIN_OBSERVER, ke);
        write_reg(lsfo_pkg::REG_STATE_SCALE, nx);
        write_reg(lsfo_pkg::REG_DRIVE_SCALE, nu);
        write_reg(lsfo_pkg::REG_REFERENCE, rl);
        write_reg(lsfo_pkg::REG_TANK_HEIGHT, th);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain_loop();
        while (cmd_queue.size() != 0 || loop_expect.size() != 0 || s_tvalid)
            @(posedge clk);
    endtask

    // Input driver: hold the current transfer until taken, else maybe idle
    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            loop_expect.push_back(step_level_loop(cmd_queue.pop_front()));
        if (s_tvalid && !s_tready)
            ;
        else if (cmd_queue.size() != 0 && $urandom_range(99) >= src_idle_pct)
        begin
            s_tvalid <= 1'b1;
            s_tuser  <= cmd_queue[0].action;
            s_tdata  <= {5'd0, cmd_queue[0].echoes};
        end
        else
            s_tvalid <= 1'b0;
    end

    // Output monitor: compare each transfer with the oldest expectation
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            seen_rpt = m_tdata;
            if (loop_expect.size() == 0)
                note_mismatch("unexpected result", m_tdata[31:0], '0);
            else
            begin
                want_rpt = loop_expect.pop_front();
                if (seen_rpt.running !== want_rpt.running)
                    note_mismatch("running", 32'(seen_rpt.running),
                                  32'(want_rpt.running));
                if (seen_rpt.measured !== want_rpt.measured)
                    note_mismatch("measured_level", seen_rpt.measured, want_rpt.measured);
                if (seen_rpt.estimate !== want_rpt.estimate)
                    note_mismatch("estimated_level", seen_rpt.estimate, want_rpt.estimate);
                if (seen_rpt.drive !== want_rpt.drive)
                    note_mismatch("drive_percent", 32'(seen_rpt.drive),
                                  32'(want_rpt.drive));
                if (seen_rpt.duty !== want_rpt.duty)
                    note_mismatch("pwm_duty", 32'(seen_rpt.duty), 32'(want_rpt.duty));
            end
            result_count++;
        end
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < 6; ph++)
        begin
            // idle modes: none, sender gaps, receiver stalls, both light
            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 55; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 55; end
                default: begin src_idle_pct = 8; sink_stall_pct = 8; end
            endcase

            case (ph)
                0: ;
                1: write_all($urandom_range(16 * 65536) - 8 * 65536,
                             $urandom_range(8 * 65536) - 4 * 65536,
                             $urandom_range(4 * 65536) - 2 * 65536,
                             $urandom_range(2 * 65536) - 65536,
                             $urandom_range(40 * 65536),
                             $urandom_range(60 * 65536, 10 * 65536));
                2: write_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                             32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
                3: write_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                             32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
                4: write_all('0, '0, '0, '0, '0, '0);
                default: write_all($urandom(), $urandom(), $urandom(),
                                   $urandom(), $urandom(), $urandom());
            endcase

            if (ph == 0)
            begin
                // stopped: ticks, ignored code and stop change nothing
                push_cmd(lsfo_pkg::ACT_TICK, 5000, 5000, 5000, 5000, 5000);
                push_cmd(ACT_IGNORED, 1160, 1160, 1160, 1160, 1160);
                push_cmd(lsfo_pkg::ACT_STOP, 0, 0, 0, 0, 0);
                push_cmd(lsfo_pkg::ACT_START, 0, 0, 0, 0, 0);
                push_cmd(lsfo_pkg::ACT_START, ECHO_ALL1, 0, ECHO_ALL1, 0, ECHO_ALL1);
                // echo extremes: all timeouts, range top, all bits set, mixed
                push_cmd(lsfo_pkg::ACT_TICK, 0, 0, 0, 0, 0);
                push_cmd(lsfo_pkg::ACT_TICK, ECHO_TOP, ECHO_TOP, ECHO_TOP, ECHO_TOP,
                         ECHO_TOP);
                push_cmd(lsfo_pkg::ACT_TICK, ECHO_ALL1, ECHO_ALL1, ECHO_ALL1, ECHO_ALL1,
                         ECHO_ALL1);
                push_cmd(lsfo_pkg::ACT_TICK, 0, ECHO_TOP, 1160, ECHO_ALL1, 2900);
                push_cmd(ACT_IGNORED, 580, 580, 580, 580, 580);
                for (int i = 0; i < 5; i++)
                    push_cmd(lsfo_pkg::ACT_TICK, lsfo_pkg::ECHO_W'(580 + i), 575, 590,
                             lsfo_pkg::ECHO_W'(580 - i), 585);
                // stop while running keeps the estimate, zeroes the drive
                push_cmd(lsfo_pkg::ACT_STOP, 0, 0, 0, 0, 0);
                push_cmd(lsfo_pkg::ACT_TICK, 580, 580, 580, 580, 580);
                push_cmd(ACT_IGNORED, 0, 0, 0, 0, 0);
                push_cmd(lsfo_pkg::ACT_START, 0, 0, 0, 0, 0);
                for (int i = 0; i < 3; i++)
                    push_cmd(lsfo_pkg::ACT_TICK, 1160, 1160, 1150, 1170, 1160);
            end

            push_cmd(lsfo_pkg::ACT_START, 0, 0, 0, 0, 0);
            repeat (152)
                cmd_queue.push_back(make_cmd());
            drain_loop();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: files.f
hdl/lsfo_pkg.sv
hdl/lsfo_serial_mul.sv
hdl/lsfo_serial_div.sv
hdl/level_state_feedback_observer_core.sv
dv/level_state_feedback_observer_core_tb.sv
